[rtl/core/grp_pkg.sv]
// Shared types, register indexes and status codes of the guillotine rectangle packer.
package grp_pkg;

  localparam int unsigned CoordW  = 15;
  localparam int unsigned RectW   = 14;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 15;

  localparam logic [CfgIdxW-1:0] CfgAtlasSide  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEdgeRepeat = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGapPixels  = 2'd2;

  localparam logic [CoordW-1:0] SideLimit = 15'd16384;
  localparam logic [CoordW-1:0] ResetSide = 15'd4096;

  typedef logic [CoordW-1:0] coord_t;

  // One free space; x sits in the lowest bits.
  typedef struct packed {
    coord_t h;
    coord_t w;
    coord_t y;
    coord_t x;
  } space_t;

  typedef enum logic [1:0] {
    ST_PLACED     = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_TOO_LARGE  = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_MOVE,
    WR_HSHRINK,
    WR_WSHRINK,
    WR_SPLIT_NEW
  } wr_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_HIT,
    S_MOVE,
    S_SPLIT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic    load;
    logic    rd_tail;
    logic    rd_next;
    logic    cap_hit;
    logic    dec_cnt;
    wr_op_e  wr_op;
    logic    out_load;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    logic too_large;
    logic empty;
    logic fit;
    logic at_bottom;
    logic exact;
    logic h_match;
    logic w_match;
    logic full;
    logic out_busy;
  } sts_t;

endpackage

[rtl/core/grp_ctrl.sv]
// Sequencing state machine of the guillotine rectangle packer.
module grp_ctrl import grp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_PLACED;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    st_d           = st_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.wr_op    = WR_NONE;
    cmd_o.out_status = st_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (sts_i.too_large) begin
          st_d    = ST_TOO_LARGE;
          state_d = S_RESULT;
        end else if (sts_i.empty) begin
          st_d    = ST_NO_FIT;
          state_d = S_RESULT;
        end else begin
          cmd_o.rd_tail = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        // One entry is checked per cycle while the next one below is fetched.
        if (sts_i.fit) begin
          cmd_o.cap_hit = 1'b1;
          state_d       = S_HIT;
        end else if (sts_i.at_bottom) begin
          st_d    = ST_NO_FIT;
          state_d = S_RESULT;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_HIT: begin
        st_d    = ST_PLACED;
        state_d = S_RESULT;
        if (sts_i.exact) begin
          // The last entry is fetched and moved into the freed slot.
          cmd_o.rd_tail = 1'b1;
          cmd_o.dec_cnt = 1'b1;
          state_d       = S_MOVE;
        end else if (sts_i.h_match) begin
          cmd_o.wr_op = WR_HSHRINK;
        end else if (sts_i.w_match) begin
          cmd_o.wr_op = WR_WSHRINK;
        end else if (sts_i.full) begin
          st_d = ST_TABLE_FULL;
        end else begin
          cmd_o.wr_op = WR_SPLIT_NEW;
          state_d     = S_SPLIT;
        end
      end
      S_MOVE: begin
        cmd_o.wr_op = WR_MOVE;
        state_d     = S_RESULT;
      end
      S_SPLIT: begin
        cmd_o.wr_op = WR_WSHRINK;
        state_d     = S_RESULT;
      end
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[rtl/core/grp_dpath.sv]
// Datapath of the guillotine rectangle packer: settings, free-space memory and result register.
module grp_dpath import grp_pkg::*; #(
  parameter int unsigned MAX_SPACES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               restart_i,
  input  logic [RectW-1:0]   rect_width_i,
  input  logic [RectW-1:0]   rect_height_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RectW-1:0]   pos_x_o,
  output logic [RectW-1:0]   pos_y_o,
  output status_e            status_o
);

  localparam int unsigned IdxW = $clog2(MAX_SPACES);
  localparam int unsigned CntW = $clog2(MAX_SPACES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SPACES);

  space_t mem [MAX_SPACES];

  coord_t          side_q;
  logic [7:0]      edge_q, gap_q;
  coord_t          eff_side;
  logic [9:0]      pad;
  coord_t          w_q, h_q;
  logic            big_q;
  logic [CntW-1:0] count_q, tail_cnt;
  logic [IdxW-1:0] tail_idx, raddr, raddr_q, hidx_q, waddr;
  logic            ovr_q, rovr_q;
  coord_t          ovr_side_q;
  space_t          rdata_q, rview, hit_q, wdata;
  logic            re, we, fit;
  coord_t          px_sum, py_sum;
  logic            out_valid_q;
  logic [RectW-1:0] px_q, py_q;
  status_e         status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= ResetSide;
      edge_q <= '0;
      gap_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAtlasSide:  side_q <= cfg_data_i;
        CfgEdgeRepeat: edge_q <= cfg_data_i[7:0];
        CfgGapPixels:  gap_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign eff_side = (side_q > SideLimit) ? SideLimit : side_q;
  assign pad      = {1'b0, edge_q, 1'b0} + {2'b00, gap_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q   <= {1'b0, rect_width_i} + CoordW'(pad);
      h_q   <= {1'b0, rect_height_i} + CoordW'(pad);
      big_q <= ({1'b0, rect_width_i} >= eff_side) || ({1'b0, rect_height_i} >= eff_side);
    end
  end

  // Entry 0 reads as the whole atlas until it is first written after a restart or reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= CntW'(1);
      ovr_q      <= 1'b1;
      ovr_side_q <= ResetSide;
    end else if (cmd_i.load && restart_i) begin
      count_q    <= CntW'(1);
      ovr_q      <= 1'b1;
      ovr_side_q <= eff_side;
    end else begin
      if (cmd_i.dec_cnt) begin
        count_q <= count_q - CntW'(1);
      end else if (cmd_i.wr_op == WR_SPLIT_NEW) begin
        count_q <= count_q + CntW'(1);
      end
      if (we && (waddr == '0)) begin
        ovr_q <= 1'b0;
      end
    end
  end

  assign tail_cnt = count_q - CntW'(1);
  assign tail_idx = tail_cnt[IdxW-1:0];
  assign re       = cmd_i.rd_tail || cmd_i.rd_next;
  assign raddr    = cmd_i.rd_tail ? tail_idx : (raddr_q - IdxW'(1));

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
      raddr_q <= raddr;
      rovr_q  <= ovr_q && (raddr == '0);
    end
  end

  always_comb begin
    if (rovr_q) begin
      rview = '{h: ovr_side_q, w: ovr_side_q, y: '0, x: '0};
    end else begin
      rview = rdata_q;
    end
  end

  assign fit = (w_q <= rview.w) && (h_q <= rview.h);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_hit) begin
      hit_q  <= rview;
      hidx_q <= raddr_q;
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = hidx_q;
    wdata = rview;
    unique case (cmd_i.wr_op)
      WR_MOVE:    wdata = rview;
      WR_HSHRINK: wdata = '{h: hit_q.h, w: hit_q.w - w_q, y: hit_q.y, x: hit_q.x + w_q};
      WR_WSHRINK: wdata = '{h: hit_q.h - h_q, w: hit_q.w, y: hit_q.y + h_q, x: hit_q.x};
      WR_SPLIT_NEW: begin
        waddr = count_q[IdxW-1:0];
        wdata = '{h: h_q, w: hit_q.w - w_q, y: hit_q.y, x: hit_q.x + w_q};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign px_sum = hit_q.x + CoordW'(edge_q);
  assign py_sum = hit_q.y + CoordW'(edge_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      px_q     <= (cmd_i.out_status == ST_PLACED) ? px_sum[RectW-1:0] : '0;
      py_q     <= (cmd_i.out_status == ST_PLACED) ? py_sum[RectW-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = px_q;
  assign pos_y_o     = py_q;
  assign status_o    = status_q;

  assign sts_o.too_large = big_q;
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.fit       = fit;
  assign sts_o.at_bottom = (raddr_q == '0);
  assign sts_o.exact     = (w_q == hit_q.w) && (h_q == hit_q.h);
  assign sts_o.h_match   = (h_q == hit_q.h);
  assign sts_o.w_match   = (w_q == hit_q.w);
  assign sts_o.full      = (count_q == MaxCnt);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt) else $error("free-space count above table depth");

  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_op == WR_SPLIT_NEW) |-> (count_q < MaxCnt))
    else $error("split appended to a full table");

  a_hit_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cap_hit |-> fit) else $error("captured a space that does not fit");

  a_move_after_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_op == WR_MOVE) |-> $past(cmd_i.rd_tail))
    else $error("entry move without a fetch of the last entry");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten while still waiting");
`endif

endmodule

[rtl/core/guillotine_rect_packer_core.sv]
// Guillotine rectangle packer for a square atlas: top level with stream and settings ports.
//
// Usage: settings are written on the cfg channel (index 0 atlas side, 1 edge repeat,
// 2 gap pixels) while the block is idle; cfg_ready_o is always high. Each input beat
// on the s_axis channel carries one rectangle (tuser = restart flag) and yields exactly
// one output beat on the m_axis channel with its position and a status code.
// The scan reads one entry of the free-space memory per cycle through its single read
// port, highest index first, and examines at most MAX_SPACES entries. After a hit, a
// shrink writes the chosen space back in place before the result is loaded; an exact
// fit first fetches the last entry and then moves it into the freed slot, and a split
// appends the new space and then shrinks the chosen one. When no space fits, the result
// is loaded right after the scan; a too-large item or an empty table skips the scan.
// One item is worked on at a time; the next one is accepted in the cycle after the current
// result is loaded, even while that result still waits to be taken.
// After reset the table holds one whole-atlas space of side 4096 and the settings hold
// their reset values; no clearing pass is needed. When the receiver stalls, the result
// is held in the output register and a following result waits until it is taken.
module guillotine_rect_packer_core import grp_pkg::*; #(
  parameter int unsigned MAX_SPACES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i,  // rect_width [13:0], rect_height [27:14], zero
  input  logic               s_axis_tuser_i,  // restart [0]
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [31:0]        m_axis_tdata_o,  // pos_x [13:0], pos_y [27:14], zero
  output logic [1:0]         m_axis_tuser_o   // status [1:0]
);

  cmd_t             cmd;
  sts_t             sts;
  logic [RectW-1:0] pos_x, pos_y;
  status_e          status;

  assign cfg_ready_o = 1'b1;

  grp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  grp_dpath #(
    .MAX_SPACES (MAX_SPACES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .restart_i     (s_axis_tuser_i),
    .rect_width_i  (s_axis_tdata_i[13:0]),
    .rect_height_i (s_axis_tdata_i[27:14]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .status_o      (status)
  );

  assign m_axis_tdata_o = {4'b0000, pos_y, pos_x};
  assign m_axis_tuser_o = status;

endmodule
